// ===== design/fcaf_pkg.sv =====
// ----------------------------------------------------------------------------
// fcaf_pkg
// Shared constants, types and helpers of the fractional comb / allpass filter.
// ----------------------------------------------------------------------------
package fcaf_pkg;

  // delay line geometry
  localparam int DELAY_DEPTH = 4096;
  localparam int ADDR_BITS   = $clog2(DELAY_DEPTH);
  localparam int FRAC_BITS   = 8;
  localparam int POS_BITS    = ADDR_BITS + FRAC_BITS;
  localparam int POS_W       = POS_BITS + 2;
  localparam int SPAN        = DELAY_DEPTH * (2 ** FRAC_BITS);

  // field widths
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 18;
  localparam int DELAY_BITS  = 20;
  localparam int CFG_BITS    = 20;
  localparam int CFG_IDX_BITS = 3;

  // width of the value handed to the saturation helper
  localparam int SAT_W = 32;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INPUT_GAIN  = 3'd0,
    REG_FEEDFORWARD = 3'd1,
    REG_FEEDBACK    = 3'd2,
    REG_DELAY       = 3'd3,
    REG_ALLPASS     = 3'd4
  } fcaf_reg_t;

  // request from the sequencer to the delay line memory
  typedef struct packed {
    logic                   rd_en;
    logic [ADDR_BITS-1:0]   rd_addr_a;
    logic [ADDR_BITS-1:0]   rd_addr_b;
    logic                   wr_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;
  } fcaf_mem_req_t;

  // clamp to the signed sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SAT_W-1:0] v
  );
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(signed'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1));
    lo = -hi - SAT_W'(signed'(1));
    if (v > hi) begin
      sat_sample = hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      sat_sample = lo[SAMPLE_BITS-1:0];
    end else begin
      sat_sample = v[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

// ===== design/fcaf_stream_if.sv =====
// ----------------------------------------------------------------------------
// fcaf stream interfaces
// Valid / ready channels carrying one input sample and one filtered sample.
// ----------------------------------------------------------------------------
interface fcaf_in_if
  import fcaf_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fcaf_out_if
  import fcaf_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== design/fcaf_delay_line.sv =====
// ----------------------------------------------------------------------------
// fcaf_delay_line
// Delay line memory: two registered read ports, one write port, and a
// clearing pass over every entry after reset.
// ----------------------------------------------------------------------------
module fcaf_delay_line
  import fcaf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  fcaf_mem_req_t          req,
  output logic [SAMPLE_BITS-1:0] rd_data_a,
  output logic [SAMPLE_BITS-1:0] rd_data_b,
  output logic                   line_ready
);

  logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
  logic [ADDR_BITS-1:0]   clr_addr;
  logic                   clearing;

  // clearing pass sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_BITS'(1);
      if (clr_addr == ADDR_BITS'(DELAY_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // write port, shared by the clearing pass and the filter
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read ports with registered data
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_a <= mem[req.rd_addr_a];
      rd_data_b <= mem[req.rd_addr_b];
    end
  end

  assign line_ready = !clearing;

endmodule

// ===== design/fractional_comb_allpass_filter_unit.sv =====
// The read / interpolate / feedback / write-back sequence runs on the single
// delay line memory; a new sample is taken only in S_IDLE, once it is done.
// Reset: registers take their defaults and a clearing pass zeroes all
// 4096 delay line entries, one per cycle; no input is taken until it ends.
// ----------------------------------------------------------------------------
// fractional_comb_allpass_filter_unit
// Comb / allpass filter with a linearly interpolated fractional delay line.
// ----------------------------------------------------------------------------
module fractional_comb_allpass_filter_unit
  import fcaf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  fcaf_in_if.sink                 din,
  fcaf_out_if.source              dout,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_INTERP   = 4'b0010,
    S_FEEDBACK = 4'b0100,
    S_OUTPUT   = 4'b1000
  } state_t;

  localparam int INTERP_W = SAMPLE_BITS + FRAC_BITS + 3;
  localparam int PROD_W   = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W    = PROD_W + 2;

  state_t state;
  state_t state_next;

  // configuration registers
  logic signed [COEF_BITS-1:0] input_gain;
  logic signed [COEF_BITS-1:0] feedforward_coeff;
  logic signed [COEF_BITS-1:0] feedback_coeff;
  logic [DELAY_BITS-1:0]       delay_length;
  logic                        allpass_mode;

  // sequencer registers
  logic [ADDR_BITS-1:0]          wp;
  logic [ADDR_BITS-1:0]          wp_next;
  logic signed [SAMPLE_BITS-1:0] x;
  logic [FRAC_BITS-1:0]          frac;
  logic signed [SAMPLE_BITS-1:0] del;
  logic signed [PROD_W-1:0]      gx;
  logic signed [SAMPLE_BITS-1:0] stored;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  // memory connection
  fcaf_mem_req_t          mem_req;
  logic [SAMPLE_BITS-1:0] rd_a;
  logic [SAMPLE_BITS-1:0] rd_b;
  logic                   line_ready;

  // read position arithmetic
  logic [POS_W-1:0]     d_sat;
  logic [POS_W-1:0]     pos_sum;
  logic [POS_W-1:0]     pos;
  logic [ADDR_BITS-1:0] i1;
  logic [ADDR_BITS-1:0] i2;

  // datapath intermediates
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [INTERP_W-1:0]    interp_sum;
  logic signed [ACC_W-1:0]       fb_acc;
  logic signed [PROD_W-1:0]      ff_prod;
  logic signed [ACC_W-1:0]       out_acc;
  logic                          accept;
  logic                          out_load;

  assign accept   = din.valid && din.ready;
  assign out_load = (state == S_OUTPUT) && (!out_valid || dout.ready);

  // configuration write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain        <= COEF_BITS'(65536);
      feedforward_coeff <= COEF_BITS'(32768);
      feedback_coeff    <= COEF_BITS'(32768);
      delay_length      <= DELAY_BITS'(1280);
      allpass_mode      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUT_GAIN:  input_gain        <= cfg_data[COEF_BITS-1:0];
        REG_FEEDFORWARD: feedforward_coeff <= cfg_data[COEF_BITS-1:0];
        REG_FEEDBACK:    feedback_coeff    <= cfg_data[COEF_BITS-1:0];
        REG_DELAY:       delay_length      <= cfg_data[DELAY_BITS-1:0];
        REG_ALLPASS:     allpass_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // write pointer advance and the fractional read position behind it
  always_comb begin
    wp_next = (wp == ADDR_BITS'(DELAY_DEPTH - 1)) ? '0 : wp + ADDR_BITS'(1);
    d_sat   = (POS_W'(delay_length) > POS_W'(SPAN)) ? POS_W'(SPAN)
                                                     : POS_W'(delay_length);
    pos_sum = POS_W'({wp_next, {FRAC_BITS{1'b0}}}) + POS_W'(SPAN) - d_sat;
    pos     = (pos_sum >= POS_W'(SPAN)) ? pos_sum - POS_W'(SPAN) : pos_sum;
    i1      = pos[POS_BITS-1:FRAC_BITS];
    i2      = (i1 == ADDR_BITS'(DELAY_DEPTH - 1)) ? '0 : i1 + ADDR_BITS'(1);
  end

  // memory request: reads on the input transaction, write-back at the end
  always_comb begin
    mem_req.rd_en     = accept;
    mem_req.rd_addr_a = i1;
    mem_req.rd_addr_b = i2;
    mem_req.wr_en     = (state == S_OUTPUT);
    mem_req.wr_addr   = wp;
    mem_req.wr_data   = stored;
  end

  fcaf_delay_line u_line (
    .clk        (clk),
    .rst        (rst),
    .req        (mem_req),
    .rd_data_a  (rd_a),
    .rd_data_b  (rd_b),
    .line_ready (line_ready)
  );

  // linear interpolation: d1 * 256 + (d2 - d1) * f, rounded
  always_comb begin
    diff       = (SAMPLE_BITS+1)'(signed'(rd_b)) - (SAMPLE_BITS+1)'(signed'(rd_a));
    frac_s     = signed'({1'b0, frac});
    interp_sum = (INTERP_W'(signed'(rd_a)) <<< FRAC_BITS)
               + INTERP_W'(diff * frac_s)
               + INTERP_W'(signed'(1 << (FRAC_BITS - 1)));
  end

  // stored value: gain * x + feedback * delayed, rounded
  always_comb begin
    fb_acc = ACC_W'(gx) + ACC_W'(feedback_coeff * del) + ACC_W'(signed'(32768));
  end

  // output: delayed plus or minus feedforward * stored, rounded
  always_comb begin
    ff_prod = feedforward_coeff * stored;
    out_acc = (ACC_W'(del) <<< 16) + ACC_W'(signed'(32768));
    if (allpass_mode) begin
      out_acc = out_acc - ACC_W'(ff_prod);
    end else begin
      out_acc = out_acc + ACC_W'(ff_prod);
    end
  end

  // sequencer state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (accept) state_next = S_INTERP;
      S_INTERP:   state_next = S_FEEDBACK;
      S_FEEDBACK: state_next = S_OUTPUT;
      S_OUTPUT:   if (out_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wp    <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        wp <= wp_next;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x    <= din.sample_in;
      frac <= pos[FRAC_BITS-1:0];
    end
    if (state == S_INTERP) begin
      del <= SAMPLE_BITS'(interp_sum >>> FRAC_BITS);
      gx  <= input_gain * x;
    end
    if (state == S_FEEDBACK) begin
      stored <= sat_sample(SAT_W'(fb_acc >>> 16));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= sat_sample(SAT_W'(out_acc >>> 16));
    end
  end

  assign din.ready       = (state == S_IDLE) && line_ready;
  assign dout.valid      = out_valid;
  assign dout.sample_out = out_sample;

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_INTERP)
    else $error("transaction accepted without starting the sequence");

  a_wp_advance: assert property (@(posedge clk) disable iff (rst)
    accept |=> wp == $past(wp_next))
    else $error("write pointer did not advance on transaction");

  a_write_only_at_end: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> (state == S_OUTPUT) && !mem_req.rd_en)
    else $error("delay line write outside write-back");

  a_result_delivered: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == S_IDLE)
    else $error("result not presented after write-back");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fractional comb / allpass filter: samples go in
// through a queue-fed driver, a monitor keeps its own copy of the delay line
// and coefficients, and every filtered sample is compared with its prediction.
// ----------------------------------------------------------------------------
module tb;
  import fcaf_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0] COEF_UNITY = COEF_BITS'(65536);
  localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  fcaf_in_if  din_ch ();
  fcaf_out_if dout_ch ();

  fractional_comb_allpass_filter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .din       (din_ch),
    .dout      (dout_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // stimulus and scoreboard bookkeeping
  logic signed [SAMPLE_BITS-1:0] samples_pending [$];
  logic signed [SAMPLE_BITS-1:0] filtered_expected [$];
  int items_issued;
  int results_seen;
  int mismatches;
  int quiet_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  logic in_taken;

  // predictor state: delay line, write pointer and register copies
  logic signed [SAMPLE_BITS-1:0] echo_line [DELAY_DEPTH];
  logic [ADDR_BITS-1:0] echo_wr_ptr;
  logic signed [COEF_BITS-1:0] gain_q;
  logic signed [COEF_BITS-1:0] ff_q;
  logic signed [COEF_BITS-1:0] fb_q;
  logic [DELAY_BITS-1:0] delay_q;
  logic allpass_q;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(input longint v);
    if (v > longint'(SAMPLE_MAX)) begin
      return SAMPLE_MAX;
    end else if (v < longint'(SAMPLE_MIN)) begin
      return SAMPLE_MIN;
    end
    return SAMPLE_BITS'(v);
  endfunction

  // one filter step: advance pointer, interpolated read, write-back, output
  function automatic logic signed [SAMPLE_BITS-1:0] comb_filter_next(
    input logic signed [SAMPLE_BITS-1:0] x
  );
    longint pos;
    longint frac;
    longint near_tap;
    longint far_tap;
    longint delayed;
    longint ffterm;
    logic [ADDR_BITS-1:0] i1;
    logic [ADDR_BITS-1:0] i2;
    logic signed [SAMPLE_BITS-1:0] stored;
    echo_wr_ptr = echo_wr_ptr + ADDR_BITS'(1);
    pos = longint'(echo_wr_ptr) * (2 ** FRAC_BITS) + longint'(SPAN) - longint'(delay_q);
    if (pos >= longint'(SPAN)) begin
      pos = pos - longint'(SPAN);
    end
    i1 = ADDR_BITS'(pos >> FRAC_BITS);
    i2 = i1 + ADDR_BITS'(1);
    frac = pos & ((2 ** FRAC_BITS) - 1);
    near_tap = longint'(echo_line[i1]);
    far_tap = longint'(echo_line[i2]);
    delayed = (far_tap * frac + near_tap * ((2 ** FRAC_BITS) - frac)
               + (2 ** (FRAC_BITS - 1))) >>> FRAC_BITS;
    stored = clamp_sample((longint'(gain_q) * longint'(x) + longint'(fb_q) * delayed
                           + 32768) >>> 16);
    echo_line[echo_wr_ptr] = stored;
    ffterm = longint'(ff_q) * longint'(stored);
    if (allpass_q) begin
      ffterm = -ffterm;
    end
    return clamp_sample(((delayed <<< 16) + ffterm + 32768) >>> 16);
  endfunction

  // driver: new sample or idle after each transaction, random receiver stalls
  always @(negedge clk) begin
    if (rst) begin
      din_ch.valid <= 1'b0;
      dout_ch.ready <= 1'b0;
    end else begin
      if (!din_ch.valid || in_taken) begin
        if (samples_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          din_ch.valid <= 1'b1;
          din_ch.sample_in <= samples_pending.pop_front();
        end else begin
          din_ch.valid <= 1'b0;
        end
      end
      dout_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: register copies, predictions, comparison and watchdog
  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (rst) begin
      for (int k = 0; k < DELAY_DEPTH; k++) begin
        echo_line[k] = '0;
      end
      echo_wr_ptr = '0;
      gain_q = COEF_UNITY;
      ff_q = COEF_BITS'(32768);
      fb_q = COEF_BITS'(32768);
      delay_q = DELAY_BITS'(1280);
      allpass_q = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INPUT_GAIN:  gain_q = cfg_data[COEF_BITS-1:0];
          REG_FEEDFORWARD: ff_q = cfg_data[COEF_BITS-1:0];
          REG_FEEDBACK:    fb_q = cfg_data[COEF_BITS-1:0];
          REG_DELAY:       delay_q = cfg_data[DELAY_BITS-1:0];
          REG_ALLPASS:     allpass_q = cfg_data[0];
          default: ;
        endcase
      end
      // output transaction against the oldest prediction
      if (dout_ch.valid && dout_ch.ready) begin
        results_seen++;
        if (filtered_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected sample_out %0d with nothing pending", dout_ch.sample_out);
          end
        end else begin
          want = filtered_expected.pop_front();
          if (dout_ch.sample_out !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("sample_out mismatch on result %0d: expected %0d, got %0d",
                       results_seen, want, dout_ch.sample_out);
            end
          end
        end
      end
      if (din_ch.valid && din_ch.ready) begin
        filtered_expected.push_back(comb_filter_next(din_ch.sample_in));
      end
      // watchdog on cycles without any transaction
      if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
    in_taken <= din_ch.valid && din_ch.ready;
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] x);
    samples_pending.push_back(x);
    items_issued++;
  endtask

  // wait until every issued sample has come back, then let the pipe drain
  task automatic drain;
    wait (results_seen >= items_issued);
    repeat (8) @(posedge clk);
  endtask

  // coefficient with the spare upper bits of the write data randomised
  function automatic logic [CFG_BITS-1:0] pick_coef();
    logic [COEF_BITS-1:0] c;
    case ($urandom_range(4))
      0: c = COEF_MAX;
      1: c = COEF_MIN;
      2: c = COEF_BITS'($urandom);
      3: c = COEF_BITS'(int'($urandom_range(98304)) - 49152);
      default: c = '0;
    endcase
    return {(CFG_BITS-COEF_BITS)'($urandom), c};
  endfunction

  task automatic random_phase(input int count);
    logic signed [SAMPLE_BITS-1:0] s;
    logic [DELAY_BITS-1:0] d;
    write_reg(REG_INPUT_GAIN, pick_coef());
    write_reg(REG_FEEDFORWARD, pick_coef());
    write_reg(REG_FEEDBACK, pick_coef());
    case ($urandom_range(3))
      0: d = DELAY_BITS'($urandom);
      1: d = DELAY_BITS'($urandom_range(255));
      default: d = DELAY_BITS'($urandom_range(64 * 256, 256));
    endcase
    write_reg(REG_DELAY, d);
    write_reg(REG_ALLPASS, CFG_BITS'($urandom));
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(3))
        1: begin
          case ($urandom_range(3))
            0: s = SAMPLE_MAX;
            1: s = SAMPLE_MIN;
            2: s = '0;
            default: s = '1;
          endcase
        end
        2: s = SAMPLE_BITS'(int'($urandom_range(8191)) - 4096);
        default: s = SAMPLE_BITS'($urandom);
      endcase
      push_sample(s);
    end
    drain();
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    din_ch.valid = 1'b0;
    din_ch.sample_in = '0;
    dout_ch.ready = 1'b0;
    items_issued = 0;
    results_seen = 0;
    mismatches = 0;
    send_idle_pct = 35;
    recv_idle_pct = 51;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default registers, sample extremes
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample('0);
    push_sample('1);
    push_sample(SAMPLE_BITS'(1));
    push_sample(SAMPLE_MAX);
    drain();

    // zero delay reads the old entry, coefficient extremes, masked upper bits
    write_reg(REG_INPUT_GAIN, {2'b11, COEF_MAX});
    write_reg(REG_FEEDFORWARD, {2'b01, COEF_MIN});
    write_reg(REG_FEEDBACK, CFG_BITS'(COEF_MAX));
    write_reg(REG_DELAY, '0);
    write_reg(REG_ALLPASS, {{(CFG_BITS-1){1'b1}}, 1'b0});
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_MIN);
    push_sample('0);
    drain();

    // delay below one sample, allpass on
    write_reg(REG_INPUT_GAIN, CFG_BITS'(COEF_MIN));
    write_reg(REG_FEEDFORWARD, CFG_BITS'(COEF_MAX));
    write_reg(REG_FEEDBACK, CFG_BITS'(COEF_MIN));
    write_reg(REG_DELAY, DELAY_BITS'(128));
    write_reg(REG_ALLPASS, {(CFG_BITS){1'b1}});
    push_sample(SAMPLE_MAX);
    push_sample('1);
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_BITS'(1));
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    drain();

    // longest delay, zero feedforward and feedback, writes to unused indexes ignored
    write_reg(REG_INPUT_GAIN, CFG_BITS'(COEF_UNITY));
    write_reg(REG_FEEDFORWARD, '0);
    write_reg(REG_FEEDBACK, '0);
    write_reg(REG_DELAY, DELAY_MAX);
    write_reg(REG_ALLPASS, '0);
    write_reg(REG_SPARE_LO, {(CFG_BITS){1'b1}});
    write_reg(REG_SPARE_HI, {(CFG_BITS){1'b1}});
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_BITS'(12345));
    push_sample('1);
    drain();

    // random phases under the three idling patterns
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 35;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase(160);
    end

    repeat (16) @(posedge clk);
    mismatches += filtered_expected.size();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/fcaf_pkg.sv
design/fcaf_stream_if.sv
design/fcaf_delay_line.sv
design/fractional_comb_allpass_filter_unit.sv
bench/tb.sv
